/* sv/swbm_pkg.sv */
// ----------------------------------------------------------------------------
// swbm_pkg: shared types for the sliding window bitrate meter
// Beat structs, opcodes and controller/datapath command and status groups.
// ----------------------------------------------------------------------------
`default_nettype none
package swbm_pkg;

    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_ERROR = 1'b1;

    localparam logic [23:0] SPAN_RESET = 24'd2000000;
    localparam logic [21:0] SCALE_Q8   = 22'd2048000;   // 8000 * 256
    localparam int          TIME_W     = 48;
    localparam int          BYTES_W    = 24;
    localparam int          PROD_W     = 64;
    localparam int          DIV_STEPS  = 64;

    // register indexes
    localparam int REG_SPAN = 0;

    typedef struct packed {
        logic        operation;
        logic [47:0] timestamp_us;
        logic [23:0] frame_bytes;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] frame_total;
        logic [31:0] error_total;
        logic [31:0] bitrate_kbps_q8;
        logic        bitrate_valid;
    } out_beat_t;

    typedef struct packed {
        logic latch_in;     // capture item, bump counter
        logic drop_full;    // drop oldest because ring is full
        logic push;         // write new entry
        logic rd_oldest;    // issue read of oldest entry
        logic pop;          // expire oldest
        logic rd_newest;    // issue read of newest entry
        logic calc_start;   // load span, set rate-valid flag
        logic mul_step;     // form product
        logic div_start;
        logic div_step;
        logic load_out;
    } swbm_cmd_t;

    typedef struct packed {
        logic is_error;
        logic ring_full;
        logic ring_empty;
        logic oldest_expired;
        logic rate_ok;
        logic div_done;
    } swbm_sts_t;

endpackage
`default_nettype wire

/* sv/swbm_datapath.sv */
// ----------------------------------------------------------------------------
// swbm_datapath: ring memory, sums, counters and shift-subtract divider
// Executes commands from the controller one step at a time.
// ----------------------------------------------------------------------------
`default_nettype none
module swbm_datapath #(
    parameter int WINDOW_DEPTH = 256
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  swbm_pkg::in_beat_t    in_beat,
    input  wire  [23:0]           span_us,
    input  swbm_pkg::swbm_cmd_t   cmd,
    output swbm_pkg::swbm_sts_t   sts,
    output swbm_pkg::out_beat_t   result
);
    import swbm_pkg::*;

    localparam int IDX_W     = $clog2(WINDOW_DEPTH);
    localparam int MEM_DEPTH = 1 << IDX_W;
    localparam int CNT_W     = IDX_W + 1;
    localparam int SUM_W     = BYTES_W + IDX_W + 1;

    // ring positions wrap at the power of two; occupancy is bounded by the depth
    logic [TIME_W-1:0]  time_mem [MEM_DEPTH];
    logic [BYTES_W-1:0] size_mem [MEM_DEPTH];

    in_beat_t            item_reg;
    logic [31:0]         frames_reg, errors_reg;
    logic [IDX_W-1:0]    oldest_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [TIME_W-1:0]   rd_time_reg, t_old_reg;
    logic [BYTES_W-1:0]  rd_size_reg;
    logic [IDX_W-1:0]    rd_addr;
    logic [IDX_W-1:0]    wr_addr;
    logic [PROD_W-1:0]   prod_reg;
    logic [TIME_W-1:0]   span_reg;
    logic [PROD_W-1:0]   quo_reg;
    logic [TIME_W:0]     rem_reg;
    logic [6:0]          step_reg;
    logic                ok_reg;
    out_beat_t           result_reg;
    logic [TIME_W:0]     rem_sh;
    logic [TIME_W+1:0]   rem_sub;

    assign wr_addr = oldest_reg + count_reg[IDX_W-1:0];
    assign rd_addr = cmd.rd_newest ? IDX_W'(oldest_reg + count_reg[IDX_W-1:0] - 1'b1)
                                   : oldest_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            time_mem[wr_addr] <= item_reg.timestamp_us;
            size_mem[wr_addr] <= item_reg.frame_bytes;
        end
        rd_time_reg <= time_mem[rd_addr];
        rd_size_reg <= size_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg <= '0;
            errors_reg <= '0;
            oldest_reg <= '0;
            count_reg  <= '0;
            sum_reg    <= '0;
            step_reg   <= '0;
            ok_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.latch_in)
            begin
                if (in_beat.operation == OP_ERROR)
                    errors_reg <= errors_reg + 32'd1;
                else
                    frames_reg <= frames_reg + 32'd1;
            end
            if (cmd.drop_full || cmd.pop)
            begin
                sum_reg    <= sum_reg - SUM_W'(rd_size_reg);
                oldest_reg <= oldest_reg + 1'b1;
                count_reg  <= count_reg - 1'b1;
            end
            if (cmd.push)
            begin
                sum_reg   <= sum_reg + SUM_W'(item_reg.frame_bytes);
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.calc_start)
                ok_reg <= (count_reg >= CNT_W'(2)) && (rd_time_reg > t_old_reg);
            if (cmd.div_start)
                step_reg <= '0;
            else if (cmd.div_step)
                step_reg <= step_reg + 7'd1;
        end
    end

    // one guard bit above the remainder so a borrow is never mistaken
    assign rem_sh  = {rem_reg[TIME_W-1:0], prod_reg[PROD_W-1]};
    assign rem_sub = {1'b0, rem_sh} - {2'b0, span_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
            item_reg <= in_beat;
        if (cmd.rd_oldest)
            ;
        if (cmd.calc_start)
            span_reg <= rd_time_reg - t_old_reg;
        if (cmd.mul_step)
            prod_reg <= PROD_W'(sum_reg) * PROD_W'(SCALE_Q8);
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            prod_reg <= {prod_reg[PROD_W-2:0], 1'b0};
            if (!rem_sub[TIME_W+1])
            begin
                rem_reg <= rem_sub[TIME_W:0];
                quo_reg <= {quo_reg[PROD_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[PROD_W-2:0], 1'b0};
            end
        end
        if (cmd.load_out)
        begin
            result_reg.frame_total     <= frames_reg;
            result_reg.error_total     <= errors_reg;
            result_reg.bitrate_valid   <= ok_reg;
            result_reg.bitrate_kbps_q8 <= !ok_reg ? 32'd0 :
                                          (|quo_reg[PROD_W-1:32]) ? 32'hFFFF_FFFF
                                                                  : quo_reg[31:0];
        end
    end

    // oldest time is captured on a pop or on the newest-entry read, when the read data holds the oldest entry
    always_ff @(posedge clk)
    begin
        if (cmd.pop || cmd.rd_newest)
            t_old_reg <= rd_time_reg;
    end

    assign sts.is_error       = item_reg.operation == OP_ERROR;
    assign sts.ring_full      = count_reg == CNT_W'(WINDOW_DEPTH);
    assign sts.ring_empty     = count_reg == '0;
    assign sts.oldest_expired = ({1'b0, rd_time_reg} + (TIME_W+1)'(span_us))
                                < {1'b0, item_reg.timestamp_us};
    assign sts.rate_ok        = ok_reg;
    assign sts.div_done       = step_reg == 7'(DIV_STEPS - 1);
    assign result             = result_reg;

endmodule
`default_nettype wire

/* sv/swbm_ctrl.sv */
// ----------------------------------------------------------------------------
// swbm_ctrl: sequencer for push, expiry, multiply and divide
// One item at a time; output register holds the beat until taken.
// ----------------------------------------------------------------------------
`default_nettype none
module swbm_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  wire                  out_stall,
    output swbm_pkg::swbm_cmd_t  cmd,
    input  swbm_pkg::swbm_sts_t  sts
);
    import swbm_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_FULLRD = 10'b0000000010,
        S_FULLW  = 10'b0000000100,
        S_PUSH   = 10'b0000001000,
        S_EXPRD  = 10'b0000010000,
        S_EXPCHK = 10'b0000100000,
        S_CALC   = 10'b0001000000,
        S_MUL    = 10'b0010000000,
        S_DIV    = 10'b0100000000,
        S_DONE   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign in_stall  = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.latch_in = accept;
                if (accept)
                    state_next = S_FULLRD;
            end
            S_FULLRD:
            begin
                cmd.rd_oldest = 1'b1;
                if (sts.is_error)
                    state_next = S_EXPRD;
                else if (sts.ring_full)
                    state_next = S_FULLW;
                else
                    state_next = S_PUSH;
            end
            S_FULLW:
            begin
                cmd.drop_full = 1'b1;
                state_next    = S_PUSH;
            end
            S_PUSH:
            begin
                cmd.push   = 1'b1;
                state_next = S_EXPRD;
            end
            S_EXPRD:
            begin
                cmd.rd_oldest = 1'b1;
                state_next    = S_EXPCHK;
            end
            S_EXPCHK:
            begin
                if (!sts.is_error && !sts.ring_empty && sts.oldest_expired)
                begin
                    cmd.pop    = 1'b1;
                    state_next = S_EXPRD;
                end
                else
                begin
                    // newest entry lands in the read register for the next step
                    cmd.rd_newest = 1'b1;
                    state_next    = S_CALC;
                end
            end
            S_CALC:
            begin
                cmd.calc_start = 1'b1;
                cmd.mul_step   = 1'b1;
                state_next     = S_MUL;
            end
            S_MUL:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done || !sts.rate_ok)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                cmd.load_out   = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

/* sv/sliding_window_bitrate_meter.sv */
// ----------------------------------------------------------------------------
// sliding_window_bitrate_meter: frame and error counters with window bitrate
// Keeps a ring of (time, bytes) entries and reports sum*8000/span in Q.8 kbps.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | beat
//  in       | input     | in_valid/in_stall  | in_beat_t (operation, time, bytes)
//  out      | output    | out_valid/out_stall| out_beat_t (totals, rate, valid)
//  cfg      | input     | APB psel/penable   | window_span_us at address 0
//
//  After acceptance a frame passes the ring read, a drop on a full ring, the
//  push, reads and checks of the oldest entry until it is not expired, then
//  span, multiply, divide and done; an error skips drop and push and pops
//  nothing. The 64-step restoring divider dominates; it stops after its first
//  step when the rate is not valid. Reset clears counters, ring pointers and
//  sets the span to 2000000 us. A held output beat stalls input until taken.
`default_nettype none
module sliding_window_bitrate_meter #(
    parameter int WINDOW_DEPTH = 256
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_stall,
    input  swbm_pkg::in_beat_t   in_data,
    output logic                 out_valid,
    input  wire                  out_stall,
    output swbm_pkg::out_beat_t  out_data,
    input  wire                  psel,
    input  wire                  penable,
    input  wire                  pwrite,
    input  wire  [1:0]           paddr,
    input  wire  [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import swbm_pkg::*;

    swbm_cmd_t   cmd;
    swbm_sts_t   sts;
    logic [23:0] span_reg;

    // Hold the span register; write only at the access phase of address zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            span_reg <= SPAN_RESET;
        else if (psel && penable && pwrite && paddr == 2'(REG_SPAN * 4))
            span_reg <= pwdata[23:0];
    end

    assign pready = 1'b1;
    assign prdata = (paddr == 2'(REG_SPAN * 4)) ? {8'd0, span_reg} : 32'd0;

    swbm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    swbm_datapath #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_beat (in_data),
        .span_us (span_reg),
        .cmd     (cmd),
        .sts     (sts),
        .result  (out_data)
    );

endmodule
`default_nettype wire

/* sv/swbm_checker.sv */
// ----------------------------------------------------------------------------
// swbm_checker: port-level checks for the bitrate meter
// Watches handshakes and result consistency at the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none
module swbm_checker (
    input wire                  clk,
    input wire                  rst_n,
    input wire                  in_valid,
    input wire                  in_stall,
    input wire                  out_valid,
    input wire                  out_stall,
    input swbm_pkg::out_beat_t  out_data
);
    import swbm_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output beat changed while stalled");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second item accepted while busy");

    a_rate_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.bitrate_valid |-> out_data.bitrate_kbps_q8 == 32'd0)
        else $error("rate nonzero while not valid");

    a_no_out_early: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid))
        else $error("result before any work");

endmodule

bind sliding_window_bitrate_meter swbm_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the sliding window bitrate meter
// Predicts totals and Q.8 window bitrate per beat, checks every output beat.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
    import swbm_pkg::*;

    localparam int DEPTH     = 256;
    localparam int MAX_CYC   = 3000000;
    localparam int SETTLE    = 400;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_beat_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_beat_t   out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    sliding_window_bitrate_meter #(.WINDOW_DEPTH(DEPTH)) DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor state
    logic [23:0] span_us;
    logic [31:0] frames_seen;
    logic [31:0] errors_seen;
    logic [47:0] ring_time [DEPTH];
    logic [23:0] ring_bytes [DEPTH];
    int          head;
    int          fill;
    logic [63:0] byte_sum;

    in_beat_t  pending_beats[$];
    out_beat_t expected_meter[$];
    int        fail_count;
    int        cycle_count;
    logic [47:0] clock_us;   // running stimulus time

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        fail_count++;
    endtask

    // Advance the meter model by one beat and return the totals and rate.
    function automatic out_beat_t meter_predict(input in_beat_t b);
        out_beat_t   r;
        logic [47:0] t_old;
        logic [47:0] t_new;
        logic [63:0] q;
        if (b.operation == OP_FRAME)
        begin
            frames_seen++;
            if (fill >= DEPTH)
            begin
                byte_sum -= ring_bytes[head];
                head = (head + 1) % DEPTH;
                fill--;
            end
            ring_time[(head + fill) % DEPTH]  = b.timestamp_us;
            ring_bytes[(head + fill) % DEPTH] = b.frame_bytes;
            fill++;
            byte_sum += b.frame_bytes;
            // expire from the oldest end; exactly at the cutoff stays
            while (fill > 0 && ({16'd0, ring_time[head]} + span_us) < {16'd0, b.timestamp_us})
            begin
                byte_sum -= ring_bytes[head];
                head = (head + 1) % DEPTH;
                fill--;
            end
        end
        else
            errors_seen++;
        r.frame_total     = frames_seen;
        r.error_total     = errors_seen;
        r.bitrate_kbps_q8 = '0;
        r.bitrate_valid   = 1'b0;
        if (fill >= 2)
        begin
            t_old = ring_time[head];
            t_new = ring_time[(head + fill - 1) % DEPTH];
            if (t_new > t_old)
            begin
                q = (byte_sum * 64'd2048000) / {16'd0, t_new - t_old};
                r.bitrate_kbps_q8 = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
                r.bitrate_valid   = 1'b1;
            end
        end
        return r;
    endfunction

    // driver: hold each beat until accepted, then draw a gap
    int drive_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            in_data   <= '0;
            drive_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_meter.push_back(meter_predict(in_data));
                drive_gap = $urandom_range(0, 3) == 0 ? 0 : int'($urandom_range(0, 18));
            end
            if (!in_valid || !in_stall)
            begin
                if (drive_gap > 0)
                begin
                    drive_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_beats.size() > 0)
                begin
                    in_data  <= pending_beats[0];
                    pending_beats.delete(0);
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: check each taken output beat, draw stalls
    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        out_beat_t want;
        if (!rst_n)
        begin
            out_stall  <= 1'b1;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_meter.size() == 0)
                begin
                    $display("output beat with nothing expected");
                    fail_count++;
                end
                else
                begin
                    want = expected_meter[0];
                    expected_meter.delete(0);
                    if (out_data.frame_total !== want.frame_total)
                        report("frame_total", 64'(out_data.frame_total),
                               64'(want.frame_total));
                    if (out_data.error_total !== want.error_total)
                        report("error_total", 64'(out_data.error_total),
                               64'(want.error_total));
                    if (out_data.bitrate_kbps_q8 !== want.bitrate_kbps_q8)
                        report("bitrate_kbps_q8", 64'(out_data.bitrate_kbps_q8),
                               64'(want.bitrate_kbps_q8));
                    if (out_data.bitrate_valid !== want.bitrate_valid)
                        report("bitrate_valid", 64'(out_data.bitrate_valid),
                               64'(want.bitrate_valid));
                end
                stall_left = $urandom_range(0, 3) == 0 ? 0 : int'($urandom_range(0, 18));
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > MAX_CYC)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Queue one beat; time advances by step and wraps at 48 bits.
    task automatic add_beat(input logic op, input logic [47:0] step, input logic [23:0] nbytes);
        in_beat_t b;
        clock_us = clock_us + step;
        b.operation    = op;
        b.timestamp_us = clock_us;
        b.frame_bytes  = nbytes;
        pending_beats.push_back(b);
    endtask

    task automatic wait_drained();
        while (pending_beats.size() > 0 || in_valid || expected_meter.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic apb_write(input logic [1:0] addr, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        span_us = value[23:0];
    endtask

    // Random phase: mostly frames at modest steps, some errors and bursts.
    task automatic random_phase(input int n, input int unsigned max_step);
        int k;
        logic [47:0] st;
        for (k = 0; k < n; k++)
        begin
            case ($urandom_range(0, 9))
                0:       st = '0;
                1:       st = 48'($urandom);
                default: st = 48'($urandom_range(0, max_step));
            endcase
            if ($urandom_range(0, 7) == 0)
                add_beat(OP_ERROR, st, 24'($urandom));
            else if ($urandom_range(0, 9) == 0)
                add_beat(OP_FRAME, st, 24'hFFFFFF - 24'($urandom_range(0, 3)));
            else
                add_beat(OP_FRAME, st, $urandom_range(0, 3) == 0 ? 24'($urandom)
                                                                 : 24'($urandom_range(0, 5000)));
        end
    endtask

    initial
    begin
        int k;
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        fail_count = 0; cycle_count = 0;
        span_us = SPAN_RESET;
        frames_seen = '0; errors_seen = '0; head = 0; fill = 0; byte_sum = '0;
        clock_us = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: error on empty ring, single frame, zero span, cutoff, extremes
        add_beat(OP_ERROR, 48'd0, 24'hFFFFFF);
        add_beat(OP_FRAME, 48'd0, 24'd0);
        add_beat(OP_FRAME, 48'd0, 24'hFFFFFF);
        add_beat(OP_FRAME, 48'd1, 24'hFFFFFF);
        add_beat(OP_ERROR, 48'd5, 24'd7);
        add_beat(OP_FRAME, 48'd1999999, 24'd100);
        add_beat(OP_FRAME, 48'd1, 24'd200);
        add_beat(OP_FRAME, 48'd2000001, 24'd300);
        add_beat(OP_FRAME, 48'd10, 24'h800000);
        wait_drained();

        // shortest span: only entries stamped now or one us back survive
        apb_write(2'(REG_SPAN * 4), 32'd1);
        add_beat(OP_FRAME, 48'd100, 24'd55);
        add_beat(OP_FRAME, 48'd1, 24'd66);
        add_beat(OP_FRAME, 48'd1, 24'd77);
        add_beat(OP_FRAME, 48'd0, 24'd88);
        random_phase(60, 2);
        wait_drained();

        // longest span: fill past ring depth so the oldest is dropped
        apb_write(2'(REG_SPAN * 4), 32'hFFFFFF);
        for (k = 0; k < DEPTH + 20; k++)
            add_beat(OP_FRAME, 48'($urandom_range(0, 40)), 24'($urandom));
        wait_drained();

        apb_write(2'(REG_SPAN * 4), 32'd1000);
        random_phase(120, 300);
        wait_drained();

        apb_write(2'(REG_SPAN * 4), {8'd0, 24'($urandom)});
        random_phase(100, 500000);
        wait_drained();

        // span write with upper bits ignored; near-max stamps
        apb_write(2'(REG_SPAN * 4), 32'hFF00_0000 | 32'd5000);
        clock_us = 48'hFFFF_FFF0_0000;
        random_phase(80, 2000);
        wait_drained();

        apb_write(2'(REG_SPAN * 4), {8'd0, SPAN_RESET});
        clock_us = 48'd0 + clock_us;
        random_phase(40, 100000);

        wait_drained();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire

/* sim.f */
sv/swbm_pkg.sv
sv/swbm_datapath.sv
sv/swbm_ctrl.sv
sv/sliding_window_bitrate_meter.sv
sv/swbm_checker.sv
tb/testbench.sv
